// ===== src/cntc_pkg.sv =====
// ----------------------------------------------------------------------------
// cntc_pkg
// Shared types, register indexes and helpers for the checked type converter.
// ----------------------------------------------------------------------------
package cntc_pkg;

    typedef enum logic [1:0] {
        ELEM_U8  = 2'd0,
        ELEM_I64 = 2'd1,
        ELEM_F32 = 2'd2,
        ELEM_F64 = 2'd3
    } t_elem_type;

    localparam logic CFG_TGT_SEL     = 1'b0;
    localparam logic CFG_CLIP_ENABLE = 1'b1;

    localparam logic [63:0] INT64_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] I64_MAX_VAL = 64'h7fff_ffff_ffff_ffff;
    localparam logic [30:0] F32_MAX_MAG = 31'h7f7f_ffff;

    // Leading zero count of a 64-bit word; 64 for an all-zero word.
    function automatic logic [6:0] lzc64(input logic [63:0] w);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (w[i]) begin
                n = 7'(63 - i);
            end
        end
        return n;
    endfunction

endpackage

// ===== src/checked_numeric_type_conversion.sv =====
// ----------------------------------------------------------------------------
// checked_numeric_type_conversion
// Converts uint8, int64, binary32 and binary64 elements to a configured
// target type, saturating or rejecting out-of-range values.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata                 tuser
//  s        in         [63:0] source_bits    [1:0] source_type
//  m        out        [63:0] result_bits    [0]   rejected
//  cfg      in         write enable, index (0 target type, 1 clip_enable), data
//
// Every request passes through the input register, where the whole
// conversion (normalize, one rounding shift, range check) is evaluated,
// and then the result register. One request is accepted per cycle while
// the output is not stalled. A stalled output holds the result register;
// the input register keeps accepting as long as the result register can
// take its request. Reset is synchronous and active low; it empties both
// stages and sets the target type to binary64 and clipping off.
// ----------------------------------------------------------------------------
module checked_numeric_type_conversion
    import cntc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] source_bits
    input  logic [1:0]  i_s_tuser,   // [1:0] source_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] result_bits
    output logic        o_m_tuser    // [0] rejected
);

    // Configuration registers.
    t_elem_type r_target;
    logic       r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= ELEM_F64;
            r_clip   <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TGT_SEL) begin
                r_target <= t_elem_type'(i_cfg_wdata);
            end else begin
                r_clip <= i_cfg_wdata[0];
            end
        end
    end

    // Pipeline handshake: the input stage moves when the result stage is free.
    logic       r_in_valid;
    t_elem_type r_src;
    logic [63:0] r_raw;
    logic       r_out_valid;
    logic [63:0] r_out_bits;
    logic       r_out_rej;
    logic       out_free;
    logic [63:0] n_out_bits;
    logic       n_out_rej;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || out_free;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_bits;
    assign o_m_tuser  = r_out_rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_src <= t_elem_type'(i_s_tuser);
            r_raw <= i_s_tdata;
        end
        if (out_free && r_in_valid) begin
            r_out_bits <= n_out_bits;
            r_out_rej  <= n_out_rej;
        end
    end

    // Unpack into sign, unbiased exponent and a 64-bit mantissa whose leading
    // one sits at bit 63; the value is mant * 2^(exp - 63).
    logic               sgn;
    logic [63:0]        pre;
    logic signed [12:0] base;
    logic [6:0]         lz;
    logic [63:0]        mant;
    logic signed [12:0] expo;
    logic               is_zero;
    logic               f32_nonfin;
    logic               f64_nonfin;
    logic               src_nonfin;
    logic               src_nan;

    assign f32_nonfin = (r_raw[30:23] == 8'hff);
    assign f64_nonfin = (r_raw[62:52] == 11'h7ff);

    always_comb begin
        sgn        = 1'b0;
        pre        = '0;
        base       = 13'sd63;
        src_nonfin = 1'b0;
        src_nan    = 1'b0;
        case (r_src)
            ELEM_U8: begin
                pre = {56'd0, r_raw[7:0]};
            end
            ELEM_I64: begin
                sgn = r_raw[63];
                pre = r_raw[63] ? (~r_raw + 64'd1) : r_raw;
            end
            ELEM_F32: begin
                sgn        = r_raw[31];
                src_nonfin = f32_nonfin;
                src_nan    = f32_nonfin && (r_raw[22:0] != 23'd0);
                if (r_raw[30:23] != 8'd0) begin
                    pre  = {1'b1, r_raw[22:0], 40'd0};
                    base = $signed({5'd0, r_raw[30:23]}) - 13'sd127;
                end else begin
                    pre  = {r_raw[22:0], 41'd0};
                    base = -13'sd127;
                end
            end
            default: begin
                sgn        = r_raw[63];
                src_nonfin = f64_nonfin;
                src_nan    = f64_nonfin && (r_raw[51:0] != 52'd0);
                if (r_raw[62:52] != 11'd0) begin
                    pre  = {1'b1, r_raw[51:0], 11'd0};
                    base = $signed({2'd0, r_raw[62:52]}) - 13'sd1023;
                end else begin
                    pre  = {r_raw[51:0], 12'd0};
                    base = -13'sd1023;
                end
            end
        endcase
    end

    assign lz      = lzc64(pre);
    assign is_zero = (pre == 64'd0);
    assign mant    = is_zero ? 64'd0 : (pre << lz);
    assign expo    = base - $signed({6'd0, lz});

    // One shared right shift with round to nearest, ties to even. The shift
    // leaves the integer part (integer targets) or the target precision in q.
    logic signed [12:0] sh_raw;
    logic [6:0]         sh;
    logic [127:0]       wide;
    logic [63:0]        q;
    logic               rnd_up;
    logic [64:0]        qr;

    always_comb begin
        case (r_target)
            ELEM_F32: begin
                sh_raw = (expo < -13'sd126) ? (13'sd40 - 13'sd126 - expo) : 13'sd40;
            end
            ELEM_F64: begin
                sh_raw = (expo < -13'sd1022) ? (13'sd11 - 13'sd1022 - expo) : 13'sd11;
            end
            default: begin
                sh_raw = 13'sd63 - expo;
            end
        endcase
        if (sh_raw < 13'sd0) begin
            sh = 7'd0;
        end else if (sh_raw > 13'sd127) begin
            sh = 7'd127;
        end else begin
            sh = sh_raw[6:0];
        end
    end

    assign wide   = {mant, 64'd0} >> sh;
    assign q      = wide[127:64];
    assign rnd_up = wide[63] && ((|wide[62:0]) || q[0]);
    assign qr     = {1'b0, q} + {64'd0, rnd_up};

    // Float packing: the exponent field minus one is added onto the rounded
    // significand so a carry out of the significand bumps the exponent.
    logic [7:0]  fld32;
    logic [10:0] fld64;
    logic [30:0] mag32;
    logic [62:0] mag64;
    logic [31:0] enc32;
    logic [63:0] enc64;

    always_comb begin
        fld32 = '0;
        fld64 = '0;
        if (!is_zero && expo >= -13'sd126) begin
            fld32 = 8'(expo + 13'sd126);
        end
        if (!is_zero && expo >= -13'sd1022) begin
            fld64 = 11'(expo + 13'sd1022);
        end
    end

    assign mag32 = {fld32, 23'd0} + qr[30:0];
    assign mag64 = {fld64, 52'd0} + qr[62:0];
    assign enc32 = {sgn, mag32};
    assign enc64 = {sgn, mag64};

    // Range checks.
    logic big_exp;
    logic u8_low;
    logic u8_high;
    logic i64_over;
    logic f32_over;

    assign big_exp  = (expo > 13'sd63);
    assign u8_low   = sgn && (big_exp || qr != 65'd0);
    assign u8_high  = !sgn && (big_exp || qr > 65'd255);
    assign i64_over = big_exp || (!sgn && qr[64:63] != 2'b00)
                      || (sgn && qr > {2'b01, 63'd0});
    assign f32_over = (expo > 13'sd127)
                      || (expo == 13'sd127 && mant[63:40] == 24'hff_ffff
                          && mant[39:0] != 40'd0);

    always_comb begin
        n_out_bits = '0;
        n_out_rej  = 1'b0;
        if (r_src == r_target) begin
            case (r_src)
                ELEM_U8:  n_out_bits = {56'd0, r_raw[7:0]};
                ELEM_F32: n_out_bits = {32'd0, r_raw[31:0]};
                default:  n_out_bits = r_raw;
            endcase
        end else if (src_nonfin) begin
            // NaN or infinity: rejected for integers, carried between floats.
            case (r_target)
                ELEM_F32: begin
                    n_out_bits = {32'd0, r_raw[63], 8'hff, src_nan, r_raw[50:29]};
                end
                ELEM_F64: begin
                    n_out_bits = {r_raw[31], 11'h7ff, src_nan, r_raw[21:0], 29'd0};
                end
                default: begin
                    n_out_rej = 1'b1;
                end
            endcase
        end else begin
            case (r_target)
                ELEM_U8: begin
                    if (u8_low || u8_high) begin
                        n_out_rej  = !r_clip;
                        n_out_bits = (r_clip && u8_high) ? 64'd255 : 64'd0;
                    end else begin
                        n_out_bits = {56'd0, qr[7:0]};
                    end
                end
                ELEM_I64: begin
                    if (i64_over) begin
                        n_out_rej  = !r_clip;
                        n_out_bits = !r_clip ? 64'd0 : (sgn ? INT64_MIN : I64_MAX_VAL);
                    end else begin
                        n_out_bits = sgn ? (~qr[63:0] + 64'd1) : qr[63:0];
                    end
                end
                ELEM_F32: begin
                    if (r_src == ELEM_F64 && f32_over) begin
                        n_out_rej  = !r_clip;
                        n_out_bits = r_clip ? {32'd0, sgn, F32_MAX_MAG} : 64'd0;
                    end else begin
                        n_out_bits = {32'd0, enc32};
                    end
                end
                default: begin
                    n_out_bits = enc64;
                end
            endcase
        end
    end

endmodule

// ===== dv/checked_numeric_type_conversion_test.sv =====
// ----------------------------------------------------------------------------
// checked_numeric_type_conversion_test
// Self-checking bench for the checked element type converter. A bit-level
// predictor works out each expected result, covering integer and float
// rounding, saturation and rejection. Directed reset and corner values come first, then
// random requests under many target and clipping settings, with bursty input
// and a stalling output.
// ----------------------------------------------------------------------------
module checked_numeric_type_conversion_test;
    import cntc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    // Largest binary32 value, widened to binary64, with the sign bit dropped.
    localparam logic [62:0] F32_MAX_AS_F64 = 63'h47ef_ffff_e000_0000;

    typedef struct packed {
        logic [63:0] bits;
        logic        rejected;
    } t_conv_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [1:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // [63:0] source_bits
    logic [1:0]  i_s_tuser;   // [1:0] source_type
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;   // [63:0] result_bits
    logic        o_m_tuser;   // [0] rejected

    // Our copy of the configuration registers, updated with every write.
    t_elem_type  cfg_target;
    logic        cfg_clip;

    t_conv_result pending_results[$];
    int unsigned  mismatch_count;
    int unsigned  cycle_count;

    // Sender burst shaping and receiver stall control.
    bit          gaps_on;
    int unsigned burst_left;
    int unsigned hold_cycles;
    bit          stall_on;

    checked_numeric_type_conversion u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Encodes sgn * m * 2^e as binary32 (f32 set) or binary64, rounding to
    // nearest with ties to even. Subnormal results are handled; the callers
    // never produce a value that would overflow to infinity.
    function automatic logic [63:0] pack_fp(input bit sgn, input logic [63:0] m,
                                            input int e, input bit f32);
        int          mant_bits;
        int          bias;
        int          msb;
        int          biased;
        int          drop;
        logic [127:0] x;
        logic [63:0] q;
        logic [63:0] word;
        mant_bits = f32 ? 23 : 52;
        bias      = f32 ? 127 : 1023;
        if (m == 64'd0) begin
            return f32 ? {32'd0, sgn, 31'd0} : {sgn, 63'd0};
        end
        msb = 63;
        while (!m[msb]) begin
            msb--;
        end
        biased = msb + e + bias;
        // Normal results keep mant_bits+1 bits; subnormal ones align to the
        // fixed weight of the smallest subnormal.
        drop = (biased >= 1) ? msb - mant_bits : (1 - bias - mant_bits) - e;
        if (drop <= 0) begin
            q = m << (-drop);
        end else begin
            if (drop > 127) begin
                drop = 127;
            end
            x = {m, 64'd0} >> drop;
            q = x[127:64];
            if (x[63] && ((|x[62:0]) || q[0])) begin
                q = q + 64'd1;
            end
        end
        // The implicit bit carries into the exponent field, so a rounding
        // carry moves up one binade on its own.
        word = (biased >= 1) ? (64'(biased - 1) << mant_bits) + q : q;
        return f32 ? {32'd0, sgn, word[30:0]} : {sgn, word[62:0]};
    endfunction

    // Splits a float into sign, integer significand and binary exponent.
    function automatic void unpack_fp(input logic [63:0] b, input bit f32,
                                      output bit sgn, output logic [63:0] m,
                                      output int e, output bit nonfinite,
                                      output bit is_nan);
        int unsigned ex;
        logic [63:0] frac;
        if (f32) begin
            sgn  = b[31];
            ex   = b[30:23];
            frac = {41'd0, b[22:0]};
            nonfinite = (ex == 255);
            m = (ex == 0) ? frac : frac | (64'd1 << 23);
            e = (ex == 0) ? -149 : int'(ex) - 150;
        end else begin
            sgn  = b[63];
            ex   = b[62:52];
            frac = {12'd0, b[51:0]};
            nonfinite = (ex == 2047);
            m = (ex == 0) ? frac : frac | (64'd1 << 52);
            e = (ex == 0) ? -1074 : int'(ex) - 1075;
        end
        is_nan = nonfinite && (frac != 64'd0);
    endfunction

    // Rounds a finite float (ties to even) and range-checks it against an
    // integer target. Returns 0 when the value is rejected.
    function automatic bit fp_to_int(input bit sgn, input logic [63:0] m,
                                     input int e, input t_elem_type tgt,
                                     input bit clip, output logic [63:0] res);
        logic [127:0] x;
        logic [63:0] mag;
        bit          huge;
        bit          neg;
        bit          over;
        int          drop;
        huge = 1'b0;
        mag  = 64'd0;
        res  = 64'd0;
        if (m != 64'd0) begin
            if (e >= 0) begin
                if (e >= 64 || (m >> (64 - e)) != 64'd0) begin
                    huge = 1'b1;
                end else begin
                    mag = m << e;
                end
            end else begin
                drop = (-e > 127) ? 127 : -e;
                x = {m, 64'd0} >> drop;
                mag = x[127:64];
                if (x[63] && ((|x[62:0]) || mag[0])) begin
                    mag = mag + 64'd1;
                end
            end
        end
        // A negative value that rounds to zero is simply zero.
        neg = sgn && (huge || mag != 64'd0);
        if (tgt == ELEM_U8) begin
            over = neg || huge || mag > 64'd255;
            if (over) begin
                if (!clip) begin
                    return 1'b0;
                end
                res = neg ? 64'd0 : 64'd255;
            end else begin
                res = mag;
            end
        end else begin
            over = huge || (neg ? mag > INT64_MIN : mag >= INT64_MIN);
            if (over) begin
                if (!clip) begin
                    return 1'b0;
                end
                res = neg ? INT64_MIN : I64_MAX_VAL;
            end else begin
                res = neg ? -mag : mag;
            end
        end
        return 1'b1;
    endfunction

    // Expected result of one request under the current configuration.
    function automatic t_conv_result convert_element(input t_elem_type src,
                                                     input logic [63:0] raw);
        t_conv_result r;
        bit          ok;
        bit          neg;
        logic [63:0] mag;
        logic [63:0] res;
        bit          sgn;
        logic [63:0] m;
        int          e;
        bit          nonfinite;
        bit          is_nan;
        ok  = 1'b1;
        res = 64'd0;
        if (src == cfg_target) begin
            // Same type: bits pass unchanged, masked to the type's width.
            case (src)
                ELEM_U8: res = {56'd0, raw[7:0]};
                ELEM_F32: res = {32'd0, raw[31:0]};
                default: res = raw;
            endcase
        end else if (src == ELEM_U8 || src == ELEM_I64) begin
            neg = (src == ELEM_I64) && raw[63];
            mag = (src == ELEM_U8) ? {56'd0, raw[7:0]} : (neg ? -raw : raw);
            case (cfg_target)
                ELEM_U8: begin
                    if (neg || mag > 64'd255) begin
                        ok  = cfg_clip;
                        res = neg ? 64'd0 : 64'd255;
                    end else begin
                        res = mag;
                    end
                end
                ELEM_I64: res = {56'd0, raw[7:0]};
                ELEM_F32: res = pack_fp(neg, mag, 0, 1'b1);
                default: res = pack_fp(neg, mag, 0, 1'b0);
            endcase
        end else if (src == ELEM_F32) begin
            unpack_fp(raw, 1'b1, sgn, m, e, nonfinite, is_nan);
            if (cfg_target == ELEM_U8 || cfg_target == ELEM_I64) begin
                // Nonfinite values never convert to an integer, clipped or not.
                ok = !nonfinite && fp_to_int(sgn, m, e, cfg_target, cfg_clip, res);
            end else if (is_nan) begin
                res = {sgn, 11'h7ff, 1'b1, raw[21:0], 29'd0};
            end else if (nonfinite) begin
                res = {sgn, 11'h7ff, 52'd0};
            end else begin
                res = pack_fp(sgn, m, e, 1'b0);
            end
        end else begin
            unpack_fp(raw, 1'b0, sgn, m, e, nonfinite, is_nan);
            if (cfg_target == ELEM_U8 || cfg_target == ELEM_I64) begin
                ok = !nonfinite && fp_to_int(sgn, m, e, cfg_target, cfg_clip, res);
            end else if (is_nan) begin
                // Payload keeps its top bits, and the quiet bit is forced.
                res = {32'd0, sgn, 8'hff, raw[51:29] | 23'h40_0000};
            end else if (nonfinite) begin
                res = {32'd0, sgn, 8'hff, 23'd0};
            end else if (raw[62:0] > F32_MAX_AS_F64) begin
                ok  = cfg_clip;
                res = {32'd0, sgn, F32_MAX_MAG};
            end else begin
                res = pack_fp(sgn, m, e, 1'b1);
            end
        end
        r.bits     = ok ? res : 64'd0;
        r.rejected = !ok;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking, timeout and the receiver
    // ------------------------------------------------------------------------

    // Outputs and tready are stable at the falling edge, so a request seen
    // here is the one taken at the next rising edge.
    always @(negedge i_clk) begin
        t_conv_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: result_bits %h rejected %b",
                       o_m_tdata, o_m_tuser);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.bits) begin
                    $error("result_bits: expected %h, actual %h", want.bits, o_m_tdata);
                    mismatch_count++;
                end
                if (o_m_tuser !== want.rejected) begin
                    $error("rejected: expected %b, actual %b", want.rejected, o_m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver switches between free-running and random stalls, and honors a
    // long hold-off when a test asks for one.
    always @(posedge i_clk) begin
        if (cycle_count % 64 == 0) begin
            stall_on = ($urandom_range(0, 2) != 0);
        end
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------------

    // Offers one request and returns at the rising edge that takes it. The
    // caller sends again at once or calls stop_sending in the same step.
    task automatic send_request(input t_elem_type src, input logic [63:0] raw);
        int unsigned gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= raw;
        i_s_tuser  <= src;
        forever begin
            @(negedge i_clk);
            if (o_s_tready) begin
                pending_results.insert(pending_results.size(),
                                       convert_element(src, raw));
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        i_s_tvalid <= 1'b0;
    endtask

    // Waits for every expected result, then for the pipeline to settle.
    task automatic drain();
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Registers are only written with the block idle.
    task automatic write_config(input t_elem_type tgt, input bit clip);
        stop_sending();
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TGT_SEL;
        i_cfg_wdata <= tgt;
        @(posedge i_clk);
        i_cfg_index <= CFG_CLIP_ENABLE;
        i_cfg_wdata <= {1'b0, clip};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_target = tgt;
        cfg_clip   = clip;
    endtask

    // Random raw bits for a source type, biased toward the interesting
    // binades: the integer ranges, the binary32 limits and rounding ties.
    function automatic logic [63:0] random_bits(input t_elem_type src);
        logic [63:0] junk;
        logic [63:0] v;
        int unsigned pick;
        junk = {$urandom, $urandom};
        pick = $urandom_range(0, 5);
        v = junk;
        case (src)
            ELEM_U8: v = junk;
            ELEM_I64: begin
                if (pick == 0) v = 64'($signed($urandom_range(0, 600)) - 300);
                else if (pick == 1) v = INT64_MIN + 64'($urandom_range(0, 3));
                else if (pick == 2) v = I64_MAX_VAL - 64'($urandom_range(0, 3));
            end
            ELEM_F32: begin
                case (pick)
                    1: v[30:23] = 8'($urandom_range(118, 192));
                    2: v[30:23] = 8'hff;
                    3: v[30:23] = 8'h00;
                    4: begin
                        v[30:23] = 8'($urandom_range(126, 136));
                        v[12:0]  = 13'd0;
                    end
                    5: v[22:0] = ($urandom_range(0, 1) != 0) ? 23'd0 : v[22:0];
                    default: ;
                endcase
            end
            default: begin
                case (pick)
                    1: v[62:52] = 11'($urandom_range(1016, 1090));
                    2: v[62:52] = ($urandom_range(0, 1) != 0) ? 11'h7ff : 11'h000;
                    3: v[62:52] = 11'($urandom_range(1146, 1152));
                    4: v[62:52] = 11'($urandom_range(860, 900));
                    5: begin
                        v[62:52] = 11'($urandom_range(1022, 1032));
                        v[39:0]  = 40'd0;
                    end
                    default: ;
                endcase
                if (pick != 0 && $urandom_range(0, 3) == 0) begin
                    v[62:0] = $urandom_range(0, 1) ? {F32_MAX_AS_F64[62:29], 29'd0} +
                              (63'($urandom_range(0, 1)) << 28) : v[62:0];
                end
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The reset configuration converts to binary64 with clipping off.
    task automatic test_reset_config();
        send_request(ELEM_U8, 64'hffff_ffff_ffff_ff80);
        send_request(ELEM_I64, INT64_MIN);
        send_request(ELEM_F32, 64'h1234_5678_ff80_0001);
        send_request(ELEM_F64, 64'h7ff4_0000_0000_0001);
        stop_sending();
    endtask

    // Corner values, each sent once with an integer target and once with a
    // float target.
    task automatic test_corner_values();
        t_elem_type  srcs[14];
        logic [63:0] vals[14];
        srcs = '{ELEM_U8, ELEM_I64, ELEM_I64, ELEM_I64, ELEM_F32, ELEM_F32,
                 ELEM_F32, ELEM_F32, ELEM_F64, ELEM_F64, ELEM_F64, ELEM_F64,
                 ELEM_F64, ELEM_F32};
        vals = '{64'hdead_beef_0000_00ff,   // uint8 max with junk above it
                 INT64_MIN, I64_MAX_VAL, 64'hffff_ffff_ffff_ffff,
                 64'hffff_0000_ffc0_0001,   // binary32 NaN with a payload
                 64'h0000_0000_ff80_0000,   // binary32 minus infinity
                 64'h0000_0000_437f_8000,   // 255.5 rounds up past uint8
                 64'h0000_0000_3f00_0000,   // 0.5 rounds to even zero
                 64'h43e0_0000_0000_0000,   // 2^63, just past int64
                 64'hc3e0_0000_0000_0000,   // -2^63, exactly in range
                 64'h47f0_0000_0000_0000,   // above the binary32 maximum
                 64'h7ff0_0000_0000_0001,   // signaling binary64 NaN
                 64'h0000_0000_0000_0001,   // smallest binary64 subnormal
                 64'h0000_0000_0000_0001};  // smallest binary32 subnormal
        write_config(ELEM_U8, 1'b0);
        foreach (vals[i]) send_request(srcs[i], vals[i]);
        write_config(ELEM_F32, 1'b1);
        foreach (vals[i]) send_request(srcs[i], vals[i]);
        stop_sending();
    endtask

    // The receiver holds off while requests keep coming, so the block fills
    // and must stall its input; afterwards everything drains out in order.
    task automatic test_backpressure();
        write_config(ELEM_I64, 1'b1);
        gaps_on = 1'b0;
        hold_cycles = 300;
        repeat (30) send_request(t_elem_type'($urandom_range(0, 3)),
                                 random_bits(ELEM_F64));
        stop_sending();
        drain();
        gaps_on = 1'b1;
    endtask

    // Random requests under a sweep of settings, the extremes included.
    task automatic test_random_traffic();
        t_elem_type src;
        for (int phase = 0; phase < 11; phase++) begin
            write_config(t_elem_type'(phase % 4), (phase / 4) % 2 == 1 ? 1'b1 :
                         (phase >= 8 ? bit'($urandom_range(0, 1)) : 1'b0));
            gaps_on = (phase % 3 != 2);
            repeat (45) begin
                src = t_elem_type'($urandom_range(0, 3));
                send_request(src, random_bits(src));
            end
        end
        stop_sending();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_TGT_SEL;
        i_cfg_wdata    = 2'd0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = 64'd0;
        i_s_tuser      = ELEM_U8;
        i_m_tready     = 1'b0;
        cfg_target     = ELEM_F64;
        cfg_clip       = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        gaps_on        = 1'b1;
        burst_left     = 0;
        hold_cycles    = 0;
        stall_on       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_corner_values();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
